// File: sv/k_way_sorted_merge_unit_defines.svh
// Assertion macros shared by the merge unit RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef K_WAY_SORTED_MERGE_UNIT_DEFINES_SVH
`define K_WAY_SORTED_MERGE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define KWSM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define KWSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/kwsm_pkg.sv
`default_nettype none

package kwsm_pkg;

	// Sizing
	localparam int NUM_LISTS   = 8;
	localparam int LIST_DEPTH  = 256;
	localparam int VALUE_WIDTH = 32;

	// Fixed port field widths
	localparam int IDX_W = 3;
	localparam int DIN_W = 32;

	// Derived widths
	localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int PTR_W  = $clog2(2 * LIST_DEPTH);
	localparam int MEM_W  = LIST_W + ADDR_W;

	localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(2 * LIST_DEPTH - 1);
	localparam logic [PTR_W-1:0]  DEPTH_PTR  = PTR_W'(LIST_DEPTH);
	localparam logic [PTR_W:0]    PTR_MOD    = (PTR_W + 1)'(2 * LIST_DEPTH);
	localparam logic [LIST_W-1:0] LIST_LAST  = LIST_W'(NUM_LISTS - 1);

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_POP    = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// One head read of the scan, as it reaches the compare unit
	typedef struct packed {
		logic              clear;
		logic              valid;
		logic              nonempty;
		logic [LIST_W-1:0] idx;
		logic [PTR_W-1:0]  head;
	} scan_ctl_t;

	// Running winner of the scan
	typedef struct packed {
		logic                   found;
		logic [LIST_W-1:0]      idx;
		logic [PTR_W-1:0]       head;
		logic [VALUE_WIDTH-1:0] value;
	} scan_res_t;

	// Advance a pointer modulo twice the list depth
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_LAST) ? '0 : p + 1'b1;
		return r;
	endfunction

	// Slot within a list for a pointer
	function automatic logic [ADDR_W-1:0] slot_of(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p >= DEPTH_PTR) ? p - DEPTH_PTR : p;
		return r[ADDR_W-1:0];
	endfunction

	// Sign-extend or truncate the input word to the stored width
	function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [DIN_W-1:0] v);
		logic [VALUE_WIDTH-1:0] r;
		for (int i = 0; i < VALUE_WIDTH; i++) begin
			r[i] = v[(i < DIN_W) ? i : DIN_W - 1];
		end
		return r;
	endfunction

	// Zero-extend or truncate a stored value to the result word
	function automatic logic [DIN_W-1:0] to_result(input logic [VALUE_WIDTH-1:0] s);
		logic [DIN_W-1:0] r;
		for (int i = 0; i < DIN_W; i++) begin
			r[i] = (i < VALUE_WIDTH) ? s[(i < VALUE_WIDTH) ? i : 0] : 1'b0;
		end
		return r;
	endfunction

	// Port list index to internal list select
	function automatic logic [LIST_W-1:0] to_sel(input logic [IDX_W-1:0] x);
		logic [LIST_W-1:0] r;
		for (int i = 0; i < LIST_W; i++) begin
			r[i] = (i < IDX_W) ? x[(i < IDX_W) ? i : 0] : 1'b0;
		end
		return r;
	endfunction

	// Internal list select to port list index
	function automatic logic [IDX_W-1:0] to_idx(input logic [LIST_W-1:0] x);
		logic [IDX_W-1:0] r;
		for (int i = 0; i < IDX_W; i++) begin
			r[i] = (i < LIST_W) ? x[(i < LIST_W) ? i : 0] : 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/k_way_sorted_merge_unit.sv
`default_nettype none
// Merge unit for up to eight ascending lists held in one element memory.
// Input channel (in_valid/in_ready): operation, list_index, value. One
// transaction is taken at a time; in_ready is high only while the unit is
// idle. Output channel (out_valid/out_ready): result_value, source_list,
// status; exactly one result per input transaction, in order.
// Append, clear and the unused code pass from acceptance to out_valid
// through an execute state and a result state. A pop passes execute, then
// walks the list heads one list per cycle through the single read port of
// the element memory in the scan state, then drain, finish and result. The
// unit returns to idle on the edge that loads the output register, so a
// new transaction is taken only once the previous result has been loaded
// into it.
// A new transaction is accepted as soon as the unit is idle, even while the
// previous result still sits in the output register; if the receiver stalls,
// the next result waits in the unit until that register frees up, and
// in_ready stays low meanwhile.
// Reset clears every head and tail pointer, so all lists start empty; the
// element memory is not cleared and needs no clearing pass. A pop reads
// every list head, but only entries an append wrote can win. Appends and
// pops never touch the memory in the same cycle, so no forwarding is needed.
`include "k_way_sorted_merge_unit_defines.svh"

module k_way_sorted_merge_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [2:0]  list_index,
	input  wire logic [31:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result_value,
	output logic [2:0]       source_list,
	output logic [1:0]       status
);

	import kwsm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DRAIN,
		S_FINISH,
		S_RESULT
	} state_t;

	state_t state_q;

	// Captured transaction
	logic [1:0]       op_q;
	logic [IDX_W-1:0] index_q;
	logic [DIN_W-1:0] value_q;

	// Pending result and output register
	logic [DIN_W-1:0] res_value_q;
	logic [IDX_W-1:0] res_src_q;
	status_t          res_status_q;
	logic             out_valid_q;
	logic [DIN_W-1:0] out_value_q;
	logic [IDX_W-1:0] out_src_q;
	logic [1:0]       out_status_q;

	// List pointers
	logic [PTR_W-1:0] head_q [NUM_LISTS];
	logic [PTR_W-1:0] tail_q [NUM_LISTS];

	// Scan control and read stage
	logic [LIST_W-1:0] scan_q;
	logic              valid_s1;
	logic              nonempty_s1;
	logic [LIST_W-1:0] idx_s1;
	logic [PTR_W-1:0]  head_s1;

	logic [LIST_W-1:0]      ptr_sel;
	logic [PTR_W-1:0]       cur_head;
	logic [PTR_W-1:0]       cur_tail;
	logic [PTR_W:0]         occ_wide;
	logic                   list_full;
	logic                   in_range;
	logic                   append_ok;
	logic                   mem_we;
	logic [MEM_W-1:0]       mem_waddr;
	logic [MEM_W-1:0]       mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_rdata;
	logic                   in_fire;
	logic                   out_free;
	scan_ctl_t              scan_ctl;
	scan_res_t              best;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Select one list for pointer reads
	assign ptr_sel  = (state_q == S_SCAN) ? scan_q : to_sel(index_q);
	assign cur_head = head_q[ptr_sel];
	assign cur_tail = tail_q[ptr_sel];

	// Occupancy of the selected list
	assign occ_wide  = (cur_tail >= cur_head)
		? {1'b0, cur_tail} - {1'b0, cur_head}
		: {1'b0, cur_tail} + PTR_MOD - {1'b0, cur_head};
	assign list_full = (occ_wide[PTR_W-1:0] == DEPTH_PTR);
	assign in_range  = (int'(index_q) < NUM_LISTS);
	assign append_ok = in_range && !list_full;

	// Element memory ports
	assign mem_we    = (state_q == S_EXEC) && (op_q == OP_APPEND) && append_ok;
	assign mem_waddr = {ptr_sel, slot_of(cur_tail)};
	assign mem_raddr = {scan_q, slot_of(cur_head)};

	kwsm_ram #(
		.DATA_W(VALUE_WIDTH),
		.ADDR_W(MEM_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(to_store(value_q)),
		.re   (state_q == S_SCAN),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Feed the compare unit
	assign scan_ctl.clear    = (state_q == S_EXEC);
	assign scan_ctl.valid    = valid_s1;
	assign scan_ctl.nonempty = nonempty_s1;
	assign scan_ctl.idx      = idx_s1;
	assign scan_ctl.head     = head_s1;

	kwsm_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (scan_ctl),
		.rdata (mem_rdata),
		.best  (best)
	);

	// Register the head read alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		nonempty_s1 <= (cur_tail != cur_head);
		idx_s1      <= scan_q;
		head_s1     <= cur_head;
	end

	// Update pointers: append bumps tail, pop bumps head, clear empties all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LISTS; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= '0;
			end
		end else if (state_q == S_EXEC && op_q == OP_CLEAR) begin
			for (int k = 0; k < NUM_LISTS; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= '0;
			end
		end else if (mem_we) begin
			tail_q[ptr_sel] <= ptr_inc(cur_tail);
		end else if (state_q == S_FINISH && best.found) begin
			head_q[best.idx] <= ptr_inc(best.head);
		end
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= operation;
			index_q <= list_index;
			value_q <= value;
		end
	end

	// Sequence each transaction and hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			scan_q       <= '0;
			res_value_q  <= '0;
			res_src_q    <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_src_q    <= '0;
			out_status_q <= '0;
		end else begin
			// Drop the output once taken, unless the result state reloads it
			if (out_valid_q && out_ready && state_q != S_RESULT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_value_q  <= '0;
					res_src_q    <= '0;
					res_status_q <= ST_OK;
					scan_q       <= '0;
					unique case (op_q)
						OP_APPEND: begin
							if (!append_ok) begin
								res_status_q <= ST_FULL;
							end
							state_q <= S_RESULT;
						end
						OP_POP: begin
							state_q <= S_SCAN;
						end
						default: begin
							state_q <= S_RESULT;
						end
					endcase
				end
				S_SCAN: begin
					if (scan_q == LIST_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (best.found) begin
						res_value_q  <= to_result(best.value);
						res_src_q    <= to_idx(best.idx);
						res_status_q <= ST_OK;
					end else begin
						res_status_q <= ST_EMPTY;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= res_value_q;
						out_src_q    <= res_src_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end else begin
						out_valid_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign source_list  = out_src_q;
	assign status       = out_status_q;

	`KWSM_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "transaction accepted while busy")
	`KWSM_ASSERT_SAME(a_write_only_exec, mem_we, state_q == S_EXEC, "element write outside execute")
	`KWSM_ASSERT_SAME(a_out_from_result, $rose(out_valid), $past(state_q) == S_RESULT, "result loaded out of sequence")
	`KWSM_ASSERT_SAME(a_empty_is_zero, out_valid && status == ST_EMPTY, result_value == '0 && source_list == '0, "empty pop carries data")

endmodule

`default_nettype wire

// File: sv/kwsm_ram.sv
`default_nettype none

module kwsm_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 11
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/kwsm_scan.sv
`default_nettype none

module kwsm_scan (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire kwsm_pkg::scan_ctl_t              ctl,
	input  wire logic [kwsm_pkg::VALUE_WIDTH-1:0] rdata,
	output kwsm_pkg::scan_res_t                   best
);

	import kwsm_pkg::*;

	logic                   found_q;
	logic [LIST_W-1:0]      idx_q;
	logic [PTR_W-1:0]       head_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   take;

	// Strictly smaller wins, so ties keep the lower list
	assign take = ctl.valid && ctl.nonempty
		&& (!found_q || ($signed(rdata) < $signed(value_q)));

	// Track winner flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// Hold winner payload
	always_ff @(posedge clk) begin
		if (take) begin
			idx_q   <= ctl.idx;
			head_q  <= ctl.head;
			value_q <= rdata;
		end
	end

	assign best.found = found_q;
	assign best.idx   = idx_q;
	assign best.head  = head_q;
	assign best.value = value_q;

endmodule

`default_nettype wire
